// ===== sv/pmff_pkg.sv =====
package pmff_pkg;

    localparam int POS_W      = 16;
    localparam int IN_W       = 136;
    localparam int CODE_W     = 6;
    localparam int VAL_W      = 32;
    localparam int DECAY_W    = 16;
    localparam int CNT_W      = 15;
    localparam int VEC_W      = 20;
    localparam int PROD_W     = 2 * VEC_W;
    localparam int CURV_W     = PROD_W + 1;
    localparam int SS_W       = 38;
    localparam int ROOT_W     = 19;
    localparam int ROOT_STEPS = 19;
    localparam int DIV_STEPS  = 32;
    localparam int ITER_W     = 5;
    localparam int Q_W        = 17;
    localparam int REC_W      = 18;

    localparam logic [DECAY_W-1:0] DECAY_RESET = 16'd100;
    localparam logic [CNT_W-1:0]   CNT_MAX     = 15'd32767;
    localparam logic [SS_W-1:0]    SLOW_LIMIT  = 38'd429496;
    localparam logic [Q_W-1:0]     ONE_Q16     = 17'h10000;

    localparam logic [3:0] OP_NONE   = 4'd0;
    localparam logic [3:0] OP_LOAD   = 4'd1;
    localparam logic [3:0] OP_PREP   = 4'd2;
    localparam logic [3:0] OP_SQA    = 4'd3;
    localparam logic [3:0] OP_SQB    = 4'd4;
    localparam logic [3:0] OP_ROOT   = 4'd5;
    localparam logic [3:0] OP_MSTORE = 4'd6;
    localparam logic [3:0] OP_CURVA  = 4'd7;
    localparam logic [3:0] OP_CURVB  = 4'd8;
    localparam logic [3:0] OP_DINIT  = 4'd9;
    localparam logic [3:0] OP_DSTEP  = 4'd10;
    localparam logic [3:0] OP_DSTORE = 4'd11;
    localparam logic [3:0] OP_COMMIT = 4'd12;

    localparam logic [2:0] JOB_ERR  = 3'd0;
    localparam logic [2:0] JOB_CG   = 3'd1;
    localparam logic [2:0] JOB_GR   = 3'd2;
    localparam logic [2:0] JOB_VEL  = 3'd3;
    localparam logic [2:0] JOB_ACC  = 3'd4;
    localparam logic [2:0] JOB_JERK = 3'd5;

    localparam logic [2:0] DIV_DECAY = 3'd0;
    localparam logic [2:0] DIV_COS   = 3'd1;
    localparam logic [2:0] DIV_SIN   = 3'd2;

    localparam logic [5:0] F_ERR_XP = 6'd0,  F_ERR_XN = 6'd1,  F_ERR_YP = 6'd2;
    localparam logic [5:0] F_ERR_YN = 6'd3,  F_ERR_MAG = 6'd4, F_ERR_DELTA = 6'd5;
    localparam logic [5:0] F_PRED_L = 6'd6,  F_PRED_R = 6'd7,  F_WAS_L = 6'd8;
    localparam logic [5:0] F_WAS_R = 6'd9,   F_DECAY = 6'd10,  F_CG_XP = 6'd11;
    localparam logic [5:0] F_CG_XN = 6'd12,  F_CG_YP = 6'd13,  F_CG_YN = 6'd14;
    localparam logic [5:0] F_CG_MAG = 6'd15, F_CG_DELTA = 6'd16, F_GR_XP = 6'd17;
    localparam logic [5:0] F_GR_XN = 6'd18,  F_GR_YP = 6'd19,  F_GR_YN = 6'd20;
    localparam logic [5:0] F_GR_MAG = 6'd21, F_GR_DELTA = 6'd22, F_V_XP = 6'd23;
    localparam logic [5:0] F_V_XN = 6'd24,   F_V_YP = 6'd25,   F_V_YN = 6'd26;
    localparam logic [5:0] F_SPEED = 6'd27,  F_A_XP = 6'd28,   F_A_XN = 6'd29;
    localparam logic [5:0] F_A_YP = 6'd30,   F_A_YN = 6'd31,   F_A_MAG = 6'd32;
    localparam logic [5:0] F_J_XP = 6'd33,   F_J_XN = 6'd34,   F_J_YP = 6'd35;
    localparam logic [5:0] F_J_YN = 6'd36,   F_J_MAG = 6'd37,  F_CURV_R = 6'd38;
    localparam logic [5:0] F_CURV_L = 6'd39, F_COS_P = 6'd40,  F_COS_N = 6'd41;
    localparam logic [5:0] F_SIN_P = 6'd42,  F_SIN_N = 6'd43,  F_HOLD_L = 6'd44;
    localparam logic [5:0] F_HOLD_R = 6'd45, F_IDLE = 6'd46;

    typedef struct packed {
        logic [3:0]        op;
        logic [2:0]        job;
        logic              load_out;
        logic [CODE_W-1:0] code;
    } pmff_cmd_t;

    typedef struct packed {
        logic out_free;
    } pmff_sts_t;

    function automatic logic [Q_W-1:0] clamp_pos(input logic signed [CURV_W-1:0] v);
        logic [Q_W-1:0] r;
        if (v < 0) begin
            r = '0;
        end else if (v > CURV_W'(65536)) begin
            r = ONE_Q16;
        end else begin
            r = v[Q_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [Q_W-1:0] clamp_mag(input logic [ROOT_W-1:0] m);
        return (m > ROOT_W'(ONE_Q16)) ? ONE_Q16 : m[Q_W-1:0];
    endfunction

    function automatic logic [VAL_W-1:0] fpos(input logic signed [CURV_W-1:0] v);
        return {{(VAL_W-Q_W){1'b0}}, clamp_pos(v)};
    endfunction

    function automatic logic [VAL_W-1:0] fneg(input logic signed [CURV_W-1:0] v);
        return {{(VAL_W-Q_W){1'b0}}, clamp_pos(-v)};
    endfunction

endpackage

// ===== sv/pmff_ctrl.sv =====
module pmff_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output pmff_pkg::pmff_cmd_t  cmd,
    input  pmff_pkg::pmff_sts_t  sts
);
    import pmff_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_PREP   = 4'd1;
    localparam logic [3:0] ST_SQA    = 4'd2;
    localparam logic [3:0] ST_SQB    = 4'd3;
    localparam logic [3:0] ST_ROOT   = 4'd4;
    localparam logic [3:0] ST_MSTORE = 4'd5;
    localparam logic [3:0] ST_CURVA  = 4'd6;
    localparam logic [3:0] ST_CURVB  = 4'd7;
    localparam logic [3:0] ST_DINIT  = 4'd8;
    localparam logic [3:0] ST_DSTEP  = 4'd9;
    localparam logic [3:0] ST_DSTORE = 4'd10;
    localparam logic [3:0] ST_COMMIT = 4'd11;
    localparam logic [3:0] ST_EMIT   = 4'd12;

    logic [3:0]        state_reg, state_next;
    logic [2:0]        job_reg, job_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    logic [CODE_W-1:0] code_reg, code_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next   = state_reg;
        job_next     = job_reg;
        iter_next    = iter_reg;
        code_next    = code_reg;
        cmd.op       = OP_NONE;
        cmd.job      = job_reg;
        cmd.load_out = 1'b0;
        cmd.code     = code_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                cmd.op     = OP_PREP;
                job_next   = JOB_ERR;
                state_next = ST_SQA;
            end
            ST_SQA: begin
                cmd.op     = OP_SQA;
                state_next = ST_SQB;
            end
            ST_SQB: begin
                cmd.op     = OP_SQB;
                iter_next  = '0;
                state_next = ST_ROOT;
            end
            ST_ROOT: begin
                cmd.op    = OP_ROOT;
                iter_next = iter_reg + 1'b1;
                if (iter_reg == ITER_W'(ROOT_STEPS - 1)) begin
                    state_next = ST_MSTORE;
                end
            end
            ST_MSTORE: begin
                cmd.op = OP_MSTORE;
                if (job_reg == JOB_JERK) begin
                    state_next = ST_CURVA;
                end else begin
                    job_next   = job_reg + 1'b1;
                    state_next = ST_SQA;
                end
            end
            ST_CURVA: begin
                cmd.op     = OP_CURVA;
                state_next = ST_CURVB;
            end
            ST_CURVB: begin
                cmd.op     = OP_CURVB;
                job_next   = DIV_DECAY;
                state_next = ST_DINIT;
            end
            ST_DINIT: begin
                cmd.op     = OP_DINIT;
                iter_next  = '0;
                state_next = ST_DSTEP;
            end
            ST_DSTEP: begin
                cmd.op    = OP_DSTEP;
                iter_next = iter_reg + 1'b1;
                if (iter_reg == ITER_W'(DIV_STEPS - 1)) begin
                    state_next = ST_DSTORE;
                end
            end
            ST_DSTORE: begin
                cmd.op = OP_DSTORE;
                if (job_reg == DIV_SIN) begin
                    state_next = ST_COMMIT;
                end else begin
                    job_next   = job_reg + 1'b1;
                    state_next = ST_DINIT;
                end
            end
            ST_COMMIT: begin
                cmd.op     = OP_COMMIT;
                code_next  = F_ERR_XP;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    code_next    = code_reg + 1'b1;
                    if (code_reg == F_IDLE) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            job_reg   <= '0;
            iter_reg  <= '0;
            code_reg  <= '0;
        end else begin
            state_reg <= state_next;
            job_reg   <= job_next;
            iter_reg  <= iter_next;
            code_reg  <= code_next;
        end
    end

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_PREP))
        else $error("accepted transfer did not start the computation");

    a_last_returns_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load_out && code_reg == F_IDLE) |=> (state_reg == ST_IDLE))
        else $error("last feature did not return to idle");

    a_job_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (job_reg <= JOB_JERK))
        else $error("job index out of range");

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (state_reg == ST_EMIT && sts.out_free))
        else $error("output loaded while busy");

endmodule

// ===== sv/pmff_datapath.sv =====
module pmff_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  pmff_pkg::pmff_cmd_t           cmd,
    output pmff_pkg::pmff_sts_t           sts,
    input  logic [pmff_pkg::IN_W-1:0]     s_tdata,
    input  logic                          cfg_we,
    input  logic [pmff_pkg::DECAY_W-1:0]  cfg_wdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [pmff_pkg::VAL_W-1:0]    m_tdata,
    output logic [pmff_pkg::CODE_W-1:0]   m_tuser,
    output logic                          m_tlast
);
    import pmff_pkg::*;

    // latched transfer
    logic [31:0]       tick_reg;
    logic [POS_W-1:0]  rx_reg, ry_reg, gx_reg, gy_reg, ls_reg, rs_reg;
    logic              ll_reg, rl_reg, press_reg;

    // block state
    logic [DECAY_W-1:0]     decay_reg;
    logic [POS_W-1:0]       prev_x_reg, prev_y_reg, cpx_reg, cpy_reg;
    logic signed [REC_W-1:0] pvx_reg, pvy_reg, pax_reg, pay_reg;
    logic [31:0]            ctick_reg;
    logic                   seen_reg;
    logic signed [REC_W-1:0] rec_reg [0:5];
    logic signed [REC_W-1:0] dist0_reg, dist1_reg, d16_reg, d22_reg;
    logic [3:0]             flags_reg;
    logic [CNT_W-1:0]       hold_l_reg, hold_r_reg, idle_reg;

    // working registers
    logic signed [VEC_W-1:0] ex_reg, ey_reg, cgx_reg, cgy_reg, grx_reg, gry_reg;
    logic signed [VEC_W-1:0] vx_reg, vy_reg, ax_reg, ay_reg, jx_reg, jy_reg;
    logic signed [PROD_W-1:0] sq_reg;
    logic [SS_W-1:0]         root_n_reg, root_r_reg, root_bit_reg, ssv_reg;
    logic [ROOT_W-1:0]       mag_e_reg, mag_cg_reg, mag_gr_reg, mag_v_reg;
    logic [ROOT_W-1:0]       mag_a_reg, mag_j_reg;
    logic signed [CURV_W-1:0] curv_reg;
    logic [31:0]             div_num_reg;
    logic [Q_W-1:0]          div_rem_reg, div_den_reg;
    logic [Q_W-1:0]          dec_val_reg, cos_q_reg, sin_q_reg;

    // output stage
    logic                    out_valid_reg;
    logic [VAL_W-1:0]        out_val_reg;
    logic [CODE_W-1:0]       out_code_reg;
    logic                    out_last_reg;

    logic signed [VEC_W-1:0] rx_s, ry_s, gx_s, gy_s, cx_s, cy_s, px_s, py_s;
    logic signed [VEC_W-1:0] vx_c, vy_c, ax_c, ay_c;
    logic signed [VEC_W-1:0] sel_a, sel_b, mul_a, mul_b, vx_abs, vy_abs;
    logic signed [PROD_W-1:0] prod;
    logic [SS_W-1:0]         ss_sum, trial;
    logic [31:0]             cte, age;
    logic                    seen_eff, decay_live, slow;
    logic [Q_W:0]            rem_sh;
    logic                    rem_ge;
    logic [CURV_W-1:0]       curv_abs;
    logic [Q_W-1:0]          curv_q;
    logic [Q_W-1:0]          mag_e_c, mag_cg_c, mag_gr_c;
    logic [VAL_W-1:0]        feat;

    assign rx_s = signed'({{(VEC_W-POS_W){1'b0}}, rx_reg});
    assign ry_s = signed'({{(VEC_W-POS_W){1'b0}}, ry_reg});
    assign gx_s = signed'({{(VEC_W-POS_W){1'b0}}, gx_reg});
    assign gy_s = signed'({{(VEC_W-POS_W){1'b0}}, gy_reg});
    assign cx_s = press_reg ? rx_s : signed'({{(VEC_W-POS_W){1'b0}}, cpx_reg});
    assign cy_s = press_reg ? ry_s : signed'({{(VEC_W-POS_W){1'b0}}, cpy_reg});
    assign px_s = signed'({{(VEC_W-POS_W){1'b0}}, prev_x_reg});
    assign py_s = signed'({{(VEC_W-POS_W){1'b0}}, prev_y_reg});
    assign vx_c = rx_s - px_s;
    assign vy_c = ry_s - py_s;
    assign ax_c = vx_c - VEC_W'(pvx_reg);
    assign ay_c = vy_c - VEC_W'(pvy_reg);

    assign cte        = press_reg ? tick_reg : ctick_reg;
    assign age        = tick_reg - cte;
    assign seen_eff   = press_reg | seen_reg;
    assign decay_live = seen_eff && (age < {16'd0, decay_reg});
    assign slow       = (ssv_reg <= SLOW_LIMIT);
    assign vx_abs     = vx_reg[VEC_W-1] ? -vx_reg : vx_reg;
    assign vy_abs     = vy_reg[VEC_W-1] ? -vy_reg : vy_reg;

    always_comb begin
        case (cmd.job)
            JOB_ERR:  begin sel_a = ex_reg;  sel_b = ey_reg;  end
            JOB_CG:   begin sel_a = cgx_reg; sel_b = cgy_reg; end
            JOB_GR:   begin sel_a = grx_reg; sel_b = gry_reg; end
            JOB_VEL:  begin sel_a = vx_reg;  sel_b = vy_reg;  end
            JOB_ACC:  begin sel_a = ax_reg;  sel_b = ay_reg;  end
            default:  begin sel_a = jx_reg;  sel_b = jy_reg;  end
        endcase
        case (cmd.op)
            OP_SQA:   begin mul_a = sel_a;  mul_b = sel_a;  end
            OP_SQB:   begin mul_a = sel_b;  mul_b = sel_b;  end
            OP_CURVB: begin mul_a = vy_reg; mul_b = ax_reg; end
            default:  begin mul_a = vx_reg; mul_b = ay_reg; end
        endcase
    end

    assign prod   = mul_a * mul_b;
    assign ss_sum = sq_reg[SS_W-1:0] + prod[SS_W-1:0];
    assign trial  = root_r_reg + root_bit_reg;
    assign rem_sh = {div_rem_reg, div_num_reg[31]};
    assign rem_ge = (rem_sh >= {1'b0, div_den_reg});

    assign curv_abs = curv_reg[CURV_W-1] ? CURV_W'(-curv_reg) : CURV_W'(curv_reg);
    assign curv_q   = clamp_pos(signed'({16'd0, curv_abs[CURV_W-1:16]}));
    assign mag_e_c  = clamp_mag(mag_e_reg);
    assign mag_cg_c = clamp_mag(mag_cg_reg);
    assign mag_gr_c = clamp_mag(mag_gr_reg);

    // working datapath
    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD: begin
                tick_reg  <= s_tdata[31:0];
                rx_reg    <= s_tdata[47:32];
                ry_reg    <= s_tdata[63:48];
                gx_reg    <= s_tdata[79:64];
                gy_reg    <= s_tdata[95:80];
                ll_reg    <= s_tdata[96];
                rl_reg    <= s_tdata[97];
                press_reg <= s_tdata[98] | s_tdata[99];
                ls_reg    <= s_tdata[115:100];
                rs_reg    <= s_tdata[131:116];
            end
            OP_PREP: begin
                ex_reg  <= rx_s - gx_s;
                ey_reg  <= ry_s - gy_s;
                cgx_reg <= cx_s - gx_s;
                cgy_reg <= cy_s - gy_s;
                grx_reg <= gx_s - rx_s;
                gry_reg <= gy_s - ry_s;
                vx_reg  <= vx_c;
                vy_reg  <= vy_c;
                ax_reg  <= ax_c;
                ay_reg  <= ay_c;
                jx_reg  <= ax_c - VEC_W'(pax_reg);
                jy_reg  <= ay_c - VEC_W'(pay_reg);
            end
            OP_SQA, OP_CURVA: begin
                sq_reg <= prod;
            end
            OP_SQB: begin
                root_n_reg   <= ss_sum;
                root_r_reg   <= '0;
                root_bit_reg <= SS_W'(1) << (2 * (ROOT_STEPS - 1));
                if (cmd.job == JOB_VEL) begin
                    ssv_reg <= ss_sum;
                end
            end
            OP_ROOT: begin
                if (root_n_reg >= trial) begin
                    root_n_reg <= root_n_reg - trial;
                    root_r_reg <= (root_r_reg >> 1) + root_bit_reg;
                end else begin
                    root_r_reg <= root_r_reg >> 1;
                end
                root_bit_reg <= root_bit_reg >> 2;
            end
            OP_MSTORE: begin
                case (cmd.job)
                    JOB_ERR: mag_e_reg  <= root_r_reg[ROOT_W-1:0];
                    JOB_CG:  mag_cg_reg <= root_r_reg[ROOT_W-1:0];
                    JOB_GR:  mag_gr_reg <= root_r_reg[ROOT_W-1:0];
                    JOB_VEL: mag_v_reg  <= root_r_reg[ROOT_W-1:0];
                    JOB_ACC: mag_a_reg  <= root_r_reg[ROOT_W-1:0];
                    default: mag_j_reg  <= root_r_reg[ROOT_W-1:0];
                endcase
            end
            OP_CURVB: begin
                curv_reg <= CURV_W'(sq_reg) - CURV_W'(prod);
            end
            OP_DINIT: begin
                div_rem_reg <= '0;
                case (cmd.job)
                    DIV_DECAY: begin
                        div_num_reg <= {decay_reg - age[15:0], 16'd0};
                        div_den_reg <= {1'b0, decay_reg};
                    end
                    DIV_COS: begin
                        div_num_reg <= {vx_abs[POS_W-1:0], 16'd0};
                        div_den_reg <= mag_v_reg[Q_W-1:0];
                    end
                    default: begin
                        div_num_reg <= {vy_abs[POS_W-1:0], 16'd0};
                        div_den_reg <= mag_v_reg[Q_W-1:0];
                    end
                endcase
            end
            OP_DSTEP: begin
                div_rem_reg <= rem_ge ? Q_W'(rem_sh - {1'b0, div_den_reg}) : rem_sh[Q_W-1:0];
                div_num_reg <= {div_num_reg[30:0], rem_ge};
            end
            OP_DSTORE: begin
                case (cmd.job)
                    DIV_DECAY: dec_val_reg <= decay_live ? div_num_reg[Q_W-1:0] : '0;
                    DIV_COS:   cos_q_reg   <= div_num_reg[Q_W-1:0];
                    default:   sin_q_reg   <= div_num_reg[Q_W-1:0];
                endcase
            end
            OP_COMMIT: begin
                d22_reg <= signed'({1'b0, mag_gr_c}) - dist1_reg;
                d16_reg <= seen_eff ? signed'({1'b0, mag_cg_c}) - dist0_reg : '0;
            end
            default: begin
            end
        endcase
    end

    // architectural state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            decay_reg  <= DECAY_RESET;
            prev_x_reg <= '0;
            prev_y_reg <= '0;
            cpx_reg    <= '0;
            cpy_reg    <= '0;
            pvx_reg    <= '0;
            pvy_reg    <= '0;
            pax_reg    <= '0;
            pay_reg    <= '0;
            ctick_reg  <= '0;
            seen_reg   <= 1'b0;
            for (int i = 0; i < 6; i++) begin
                rec_reg[i] <= '0;
            end
            dist0_reg  <= '0;
            dist1_reg  <= '0;
            flags_reg  <= '0;
            hold_l_reg <= '0;
            hold_r_reg <= '0;
            idle_reg   <= '0;
        end else begin
            if (cfg_we) begin
                decay_reg <= (cfg_wdata == '0) ? DECAY_W'(1) : cfg_wdata;
            end
            if (cmd.op == OP_COMMIT) begin
                if (press_reg) begin
                    ctick_reg  <= tick_reg;
                    seen_reg   <= 1'b1;
                    rec_reg[0] <= signed'({1'b0, clamp_pos(CURV_W'(ex_reg))});
                    rec_reg[1] <= signed'({1'b0, clamp_pos(-CURV_W'(ex_reg))});
                    rec_reg[2] <= signed'({1'b0, clamp_pos(CURV_W'(ey_reg))});
                    rec_reg[3] <= signed'({1'b0, clamp_pos(-CURV_W'(ey_reg))});
                    rec_reg[4] <= signed'({1'b0, mag_e_c});
                    rec_reg[5] <= signed'({1'b0, mag_e_c}) - rec_reg[4];
                    flags_reg  <= {rl_reg, ll_reg, rl_reg && (rs_reg > ls_reg),
                                   ll_reg && (ls_reg > rs_reg)};
                    cpx_reg    <= rx_reg;
                    cpy_reg    <= ry_reg;
                end
                dist0_reg  <= seen_eff ? signed'({1'b0, mag_cg_c}) : '0;
                dist1_reg  <= signed'({1'b0, mag_gr_c});
                hold_l_reg <= !ll_reg ? '0 :
                              (hold_l_reg >= CNT_MAX) ? CNT_MAX : hold_l_reg + 1'b1;
                hold_r_reg <= !rl_reg ? '0 :
                              (hold_r_reg >= CNT_MAX) ? CNT_MAX : hold_r_reg + 1'b1;
                idle_reg   <= !slow ? '0 :
                              (idle_reg >= CNT_MAX) ? CNT_MAX : idle_reg + 1'b1;
                prev_x_reg <= rx_reg;
                prev_y_reg <= ry_reg;
                pvx_reg    <= REC_W'(vx_reg);
                pvy_reg    <= REC_W'(vy_reg);
                pax_reg    <= signed'({1'b0, clamp_pos(CURV_W'(ax_reg))})
                              - signed'({1'b0, clamp_pos(-CURV_W'(ax_reg))});
                pay_reg    <= signed'({1'b0, clamp_pos(CURV_W'(ay_reg))})
                              - signed'({1'b0, clamp_pos(-CURV_W'(ay_reg))});
            end
        end
    end

    // feature select
    always_comb begin
        case (cmd.code)
            F_ERR_XP:    feat = VAL_W'(rec_reg[0]);
            F_ERR_XN:    feat = VAL_W'(rec_reg[1]);
            F_ERR_YP:    feat = VAL_W'(rec_reg[2]);
            F_ERR_YN:    feat = VAL_W'(rec_reg[3]);
            F_ERR_MAG:   feat = VAL_W'(rec_reg[4]);
            F_ERR_DELTA: feat = VAL_W'(rec_reg[5]);
            F_PRED_L:    feat = flags_reg[0] ? VAL_W'(ONE_Q16) : '0;
            F_PRED_R:    feat = flags_reg[1] ? VAL_W'(ONE_Q16) : '0;
            F_WAS_L:     feat = flags_reg[2] ? VAL_W'(ONE_Q16) : '0;
            F_WAS_R:     feat = flags_reg[3] ? VAL_W'(ONE_Q16) : '0;
            F_DECAY:     feat = VAL_W'(dec_val_reg);
            F_CG_XP:     feat = seen_reg ? fpos(CURV_W'(cgx_reg)) : '0;
            F_CG_XN:     feat = seen_reg ? fneg(CURV_W'(cgx_reg)) : '0;
            F_CG_YP:     feat = seen_reg ? fpos(CURV_W'(cgy_reg)) : '0;
            F_CG_YN:     feat = seen_reg ? fneg(CURV_W'(cgy_reg)) : '0;
            F_CG_MAG:    feat = VAL_W'(dist0_reg);
            F_CG_DELTA:  feat = VAL_W'(d16_reg);
            F_GR_XP:     feat = fpos(CURV_W'(grx_reg));
            F_GR_XN:     feat = fneg(CURV_W'(grx_reg));
            F_GR_YP:     feat = fpos(CURV_W'(gry_reg));
            F_GR_YN:     feat = fneg(CURV_W'(gry_reg));
            F_GR_MAG:    feat = VAL_W'(dist1_reg);
            F_GR_DELTA:  feat = VAL_W'(d22_reg);
            F_V_XP:      feat = fpos(CURV_W'(vx_reg));
            F_V_XN:      feat = fneg(CURV_W'(vx_reg));
            F_V_YP:      feat = fpos(CURV_W'(vy_reg));
            F_V_YN:      feat = fneg(CURV_W'(vy_reg));
            F_SPEED:     feat = VAL_W'(clamp_mag(mag_v_reg));
            F_A_XP:      feat = fpos(CURV_W'(ax_reg));
            F_A_XN:      feat = fneg(CURV_W'(ax_reg));
            F_A_YP:      feat = fpos(CURV_W'(ay_reg));
            F_A_YN:      feat = fneg(CURV_W'(ay_reg));
            F_A_MAG:     feat = VAL_W'(clamp_mag(mag_a_reg));
            F_J_XP:      feat = fpos(CURV_W'(jx_reg));
            F_J_XN:      feat = fneg(CURV_W'(jx_reg));
            F_J_YP:      feat = fpos(CURV_W'(jy_reg));
            F_J_YN:      feat = fneg(CURV_W'(jy_reg));
            F_J_MAG:     feat = VAL_W'(clamp_mag(mag_j_reg));
            F_CURV_R:    feat = curv_reg[CURV_W-1] ? '0 : VAL_W'(curv_q);
            F_CURV_L:    feat = curv_reg[CURV_W-1] ? VAL_W'(curv_q) : '0;
            F_COS_P:     feat = (slow || vx_reg[VEC_W-1]) ? '0 : VAL_W'(cos_q_reg);
            F_COS_N:     feat = (slow || !vx_reg[VEC_W-1]) ? '0 : VAL_W'(cos_q_reg);
            F_SIN_P:     feat = (slow || vy_reg[VEC_W-1]) ? '0 : VAL_W'(sin_q_reg);
            F_SIN_N:     feat = (slow || !vy_reg[VEC_W-1]) ? '0 : VAL_W'(sin_q_reg);
            F_HOLD_L:    feat = {{(VAL_W-CNT_W-16){1'b0}}, hold_l_reg, 16'd0};
            F_HOLD_R:    feat = {{(VAL_W-CNT_W-16){1'b0}}, hold_r_reg, 16'd0};
            F_IDLE:      feat = {{(VAL_W-CNT_W-16){1'b0}}, idle_reg, 16'd0};
            default:     feat = '0;
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_val_reg  <= feat;
            out_code_reg <= cmd.code;
            out_last_reg <= (cmd.code == F_IDLE);
        end
    end

    assign sts.out_free = !out_valid_reg || m_tready;
    assign m_tvalid     = out_valid_reg;
    assign m_tdata      = out_val_reg;
    assign m_tuser      = out_code_reg;
    assign m_tlast      = out_last_reg;

endmodule

// ===== sv/pointer_motion_feedback_features.sv =====
// Pointer motion feedback features.
// Input stream (s_*): one transfer per pointer tick carrying the tick number,
// real and predicted position, button levels, press edges and the two
// predicted button scores. Output stream (m_*): 47 transfers per tick, the
// feature value in m_tdata (signed Q15.16), its code in m_tuser, and m_tlast
// on the final feature of the tick.
// The block works on one tick at a time. After a transfer is taken it runs
// six magnitudes through an iterative square root, then the curvature
// products, then three 32-step divisions, then the state commit, followed by
// the 47 output transfers. s_tready is high only between ticks, so a new
// tick is not taken before the last one is through.
// A stalled receiver holds the output register; the feature sequence waits
// and resumes without loss. cfg_we writes decay_ticks (0 is stored as 1).
// Reset (aresetn low, synchronous) clears all history and counters and
// sets decay_ticks to 100.
module pointer_motion_feedback_features (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    // tick, real_x, real_y, guess_x, guess_y, left_level, right_level,
    // left_edge, right_edge, guess_left_score, guess_right_score, zero pad
    input  logic [135:0]  s_tdata,
    output logic          m_tvalid,
    input  logic          m_tready,
    // feature_value
    output logic [31:0]   m_tdata,
    // feature_code
    output logic [5:0]    m_tuser,
    output logic          m_tlast,
    input  logic          cfg_we,
    input  logic [15:0]   cfg_wdata
);
    import pmff_pkg::*;

    pmff_cmd_t cmd;
    pmff_sts_t sts;

    pmff_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    pmff_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
